[rtl/core/looping_voice_sample_mixer_assert.svh]
// assertion macros for the voice mixer core
`ifndef LOOPING_VOICE_SAMPLE_MIXER_ASSERT_SVH
`define LOOPING_VOICE_SAMPLE_MIXER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LVSM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lvsm assertion failed");

// next-cycle implication, disabled while reset is low
`define LVSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lvsm assertion failed");

`endif

[rtl/core/lvsm_pkg.sv]
// shared types and constants of the voice mixer
`timescale 1ns / 1ps
`default_nettype none

package lvsm_pkg;

	// command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// clip length and position width
	localparam int LEN_W = 17;

	// sample memory depth, a power of two so addresses wrap by truncation
	localparam int SAMPLE_DEPTH = 65536;

	// saturation limits of the mix
	localparam logic signed [15:0] MIX_MAX = 16'sh7FFF;
	localparam logic signed [15:0] MIX_MIN = 16'sh8000;

	// control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMMIT,
		ST_VRD,
		ST_VEV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[rtl/core/looping_voice_sample_mixer.sv]
// multi-voice saturating pcm mixer over one shared sample memory
// write and start commands are taken in the idle state and carried out in the commit state
// a tick walks the slots in turn: a state read per slot, then for each active voice a sample
// read, or its drop if a one-shot clip has ended; the mix is registered after the last slot
// one item is in work at a time; a finished tick waits while the previous mix is stalled
// reset clears all voices to inactive and empties the output; sample memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

`include "looping_voice_sample_mixer_assert.svh"

module looping_voice_sample_mixer
	import lvsm_pkg::*;
#(
	parameter int NUM_VOICES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [15:0]        address,
	input  wire logic signed [15:0] sample_in,
	input  wire logic [2:0]         voice_slot,
	input  wire logic [16:0]        clip_length,
	input  wire logic               loop_enable,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      mix_sample,
	output logic                    clipped,
	output logic [7:0]              active_mask
);

	localparam int AW = $clog2(SAMPLE_DEPTH);
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SW = 17 + $clog2(NUM_VOICES);

	typedef struct packed {
		logic [AW-1:0]    base;
		logic [AW-1:0]    addr;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] pos;
		logic             loop;
	} voice_t;

	// memories
	logic signed [15:0] smem [SAMPLE_DEPTH];
	voice_t             vmem [NUM_VOICES];

	state_t state_q, state_d;

	// captured command
	logic [1:0]         cmd_q;
	logic [15:0]        address_q;
	logic signed [15:0] sample_q;
	logic [2:0]         slot_q;
	logic [LEN_W-1:0]   len_q;
	logic               loop_q;

	logic [VW-1:0]      vidx_q;
	logic [NUM_VOICES-1:0] active_q;
	voice_t             vm_rd_q;
	logic signed [15:0] sm_rd_q;
	logic               pend_q;
	logic signed [SW-1:0] sum_q;

	logic               out_valid_q;
	logic signed [15:0] mix_q;
	logic               clip_q;
	logic [7:0]         mask_q;

	logic in_accept;
	logic out_free;
	logic last_voice;
	logic slot_ok;

	// voice evaluation
	logic             at_end;
	logic             drop;
	logic [LEN_W-1:0] use_pos;
	logic [AW-1:0]    use_addr;
	logic [AW:0]      addr_inc;
	logic [AW-1:0]    addr_nxt;
	voice_t           vm_wdata;
	logic [VW-1:0]    vm_waddr;
	logic             vm_we;
	logic             sm_we;
	logic             sm_re;

	logic signed [SW-1:0] sum_fin;
	logic [7:0]           mask_w;

	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign last_voice = (vidx_q == VW'(NUM_VOICES - 1));
	assign slot_ok    = (32'(slot_q) < NUM_VOICES);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (cmd) inside
						CMD_WRITE, CMD_START: state_d = ST_COMMIT;
						CMD_TICK:             state_d = ST_VRD;
						default:              state_d = ST_IDLE;
					endcase
				end
			end
			ST_COMMIT: state_d = ST_IDLE;
			ST_VRD: begin
				if (active_q[vidx_q]) begin
					state_d = ST_VEV;
				end else if (last_voice) begin
					state_d = ST_DONE;
				end
			end
			ST_VEV: state_d = last_voice ? ST_DONE : ST_VRD;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// capture the command on transfer
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q     <= cmd;
			address_q <= address;
			sample_q  <= sample_in;
			slot_q    <= voice_slot;
			len_q     <= clip_length;
			loop_q    <= loop_enable;
		end
	end

	// voice walk index
	always_ff @(posedge clk) begin
		if (in_accept) begin
			vidx_q <= '0;
		end else if (((state_q == ST_VRD) && !active_q[vidx_q]) || (state_q == ST_VEV)) begin
			if (!last_voice) begin
				vidx_q <= vidx_q + VW'(1);
			end
		end
	end

	// end-of-clip handling for the voice just read
	always_comb begin
		at_end   = (vm_rd_q.pos >= vm_rd_q.len);
		drop     = at_end && !vm_rd_q.loop;
		use_pos  = at_end ? '0 : vm_rd_q.pos;
		use_addr = at_end ? vm_rd_q.base : vm_rd_q.addr;
		addr_inc = {1'b0, use_addr} + (AW+1)'(1);
		addr_nxt = (addr_inc == (AW+1)'(SAMPLE_DEPTH)) ? '0 : addr_inc[AW-1:0];
	end

	// voice memory write port: start commit or tick write-back
	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = vidx_q;
		vm_wdata = '{base: vm_rd_q.base, addr: addr_nxt, len: vm_rd_q.len,
			pos: use_pos + LEN_W'(1), loop: vm_rd_q.loop};
		sm_re    = (state_q == ST_VEV) && !drop;
		sm_we    = (state_q == ST_COMMIT) && (cmd_q == CMD_WRITE);
		if ((state_q == ST_COMMIT) && (cmd_q == CMD_START) && slot_ok) begin
			vm_we    = 1'b1;
			vm_waddr = VW'(slot_q);
			vm_wdata = '{base: address_q, addr: address_q, len: len_q, pos: '0, loop: loop_q};
		end else if (sm_re) begin
			vm_we = 1'b1;
		end
	end

	// voice state memory
	always_ff @(posedge clk) begin
		if (vm_we) begin
			vmem[vm_waddr] <= vm_wdata;
		end
		if (state_q == ST_VRD) begin
			vm_rd_q <= vmem[vidx_q];
		end
	end

	// sample memory
	always_ff @(posedge clk) begin
		if (sm_we) begin
			smem[address_q] <= sample_q;
		end
		if (sm_re) begin
			sm_rd_q <= smem[use_addr];
		end
	end

	// active flags and pending sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			pend_q <= sm_re;
			if ((state_q == ST_COMMIT) && (cmd_q == CMD_START) && slot_ok) begin
				active_q[VW'(slot_q)] <= (len_q != '0);
			end else if ((state_q == ST_VEV) && drop) begin
				active_q[vidx_q] <= 1'b0;
			end
		end
	end

	// running sum, one sample added the cycle after its read
	always_ff @(posedge clk) begin
		if (in_accept) begin
			sum_q <= '0;
		end else if (pend_q) begin
			sum_q <= sum_q + SW'(sm_rd_q);
		end
	end

	assign sum_fin = sum_q + (pend_q ? SW'(sm_rd_q) : SW'(0));

	// mask of the reported slots
	for (genvar i = 0; i < 8; i++) begin : g_mask
		if (i < NUM_VOICES) begin : g_on
			assign mask_w[i] = active_q[i];
		end else begin : g_off
			assign mask_w[i] = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			mask_q <= mask_w;
			if (sum_fin > SW'(MIX_MAX)) begin
				mix_q  <= MIX_MAX;
				clip_q <= 1'b1;
			end else if (sum_fin < SW'(MIX_MIN)) begin
				mix_q  <= MIX_MIN;
				clip_q <= 1'b1;
			end else begin
				mix_q  <= sum_fin[15:0];
				clip_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign mix_sample  = mix_q;
	assign clipped     = clip_q;
	assign active_mask = mask_q;

	// checks
	`LVSM_ASSERT_NOW(a_clip_at_limit, clk, arst_n, out_valid && clipped,
		(mix_sample == MIX_MAX) || (mix_sample == MIX_MIN))
	`LVSM_ASSERT_NEXT(a_active_set_on_start, clk, arst_n, state_q != ST_COMMIT,
		(active_q & ~$past(active_q)) == '0)
	`LVSM_ASSERT_NOW(a_pend_in_walk, clk, arst_n, pend_q,
		(state_q == ST_VRD) || (state_q == ST_DONE))
	`LVSM_ASSERT_NOW(a_result_from_done, clk, arst_n, $rose(out_valid),
		$past(state_q) == ST_DONE)

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking testbench of the voice mixer: directed table, then random commands
`timescale 1ns / 1ps

module tb_top;
	import lvsm_pkg::*;

	localparam int NVOICE = 8;
	localparam int RAND_ITEMS = 1350;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [15:0] smp;
		logic [2:0]  slot;
		logic [16:0] len;
		logic        loop;
	} mix_cmd_t;

	typedef struct packed {
		logic [15:0] mix;
		logic        clip;
		logic [7:0]  mask;
	} mix_res_t;

	typedef struct packed {
		mix_cmd_t op;
		logic     typed;
		mix_res_t want;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [15:0]        address;
	logic signed [15:0] sample_in;
	logic [2:0]         voice_slot;
	logic [16:0]        clip_length;
	logic               loop_enable;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] mix_sample;
	logic               clipped;
	logic [7:0]         active_mask;

	// shadow of the mixer state
	logic signed [15:0] pcm_mem [0:65535];
	bit                 pcm_written [0:65535];
	logic [15:0]        vc_base [NVOICE];
	logic [16:0]        vc_len [NVOICE];
	logic [16:0]        vc_pos [NVOICE];
	bit                 vc_loop [NVOICE];
	bit                 vc_active [NVOICE];

	mix_res_t mix_expected [$];
	mix_res_t mon_want;
	dir_row_t dir_tab [$];
	int       fail_count;
	int       items_sent;
	bit       quiet;
	bit       hold_go;

	looping_voice_sample_mixer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.address     (address),
		.sample_in   (sample_in),
		.voice_slot  (voice_slot),
		.clip_length (clip_length),
		.loop_enable (loop_enable),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.mix_sample  (mix_sample),
		.clipped     (clipped),
		.active_mask (active_mask)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	// advance the shadow state by one command, returns 1 when a mix comes out
	function automatic bit mixer_apply(input mix_cmd_t op, output mix_res_t res);
		int sum;
		int s;
		logic [16:0] rd;
		res = '0;
		case (op.cmd)
			CMD_WRITE: begin
				pcm_mem[op.addr] = op.smp;
				pcm_written[op.addr] = 1'b1;
				return 1'b0;
			end
			CMD_START: begin
				vc_base[op.slot] = op.addr;
				vc_len[op.slot] = op.len;
				vc_pos[op.slot] = '0;
				vc_loop[op.slot] = op.loop;
				vc_active[op.slot] = (op.len != '0);
				return 1'b0;
			end
			CMD_TICK: begin
				sum = 0;
				for (s = 0; s < NVOICE; s++) begin
					if (!vc_active[s])
						continue;
					// end of clip: wrap or drop out
					if (vc_pos[s] >= vc_len[s]) begin
						if (vc_loop[s]) begin
							vc_pos[s] = '0;
						end else begin
							vc_active[s] = 1'b0;
							continue;
						end
					end
					rd = {1'b0, vc_base[s]} + vc_pos[s];
					sum += pcm_mem[rd[15:0]];
					vc_pos[s] = vc_pos[s] + 17'd1;
				end
				// saturate to 16 bits
				if (sum > MIX_MAX) begin
					res.mix = MIX_MAX;
					res.clip = 1'b1;
				end else if (sum < MIX_MIN) begin
					res.mix = MIX_MIN;
					res.clip = 1'b1;
				end else begin
					res.mix = sum[15:0];
				end
				for (s = 0; s < NVOICE; s++)
					res.mask[s] = vc_active[s];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic mix_cmd_t rand_fields();
		mix_cmd_t op;
		op.cmd = 2'($urandom_range(3));
		op.addr = 16'($urandom);
		op.smp = 16'($urandom);
		op.slot = 3'($urandom);
		op.len = 17'($urandom);
		op.loop = 1'($urandom);
		return op;
	endfunction

	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 15) begin
			case ($urandom_range(3))
				0: return 16'h7FFF;
				1: return 16'h8000;
				2: return 16'hFFFF;
				default: return 16'h0000;
			endcase
		end
		if (r < 45)
			return 16'($signed($urandom_range(4000)) - 2000);
		return 16'($urandom);
	endfunction

	// mostly a small pool around the address wrap, sometimes anywhere
	function automatic logic [15:0] pool_addr();
		if ($urandom_range(99) < 15)
			return 16'($urandom);
		return 16'(16'hFFE0 + $urandom_range(79));
	endfunction

	function automatic dir_row_t dir_row(input logic [1:0] c, input logic [15:0] a,
			input logic [15:0] smp, input logic [2:0] sl, input logic [16:0] len,
			input logic lp, input logic typed, input logic [15:0] mix,
			input logic clip, input logic [7:0] mask);
		dir_row_t r;
		r.op = '{cmd: c, addr: a, smp: smp, slot: sl, len: len, loop: lp};
		r.typed = typed;
		r.want = '{mix: mix, clip: clip, mask: mask};
		return r;
	endfunction

	// append one row to the directed table
	function automatic void tab_add(input dir_row_t r);
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	// offer one command, wait for its transfer, then record what it should produce
	task automatic drive_item(input mix_cmd_t op, input logic typed, input mix_res_t want);
		int gap;
		mix_res_t res;
		if (!quiet && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op.cmd;
		address <= op.addr;
		sample_in <= op.smp;
		voice_slot <= op.slot;
		clip_length <= op.len;
		loop_enable <= op.loop;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (mixer_apply(op, res))
			mix_expected.insert(mix_expected.size(), typed ? want : res);
		if (op.cmd != CMD_UNUSED)
			items_sent++;
	endtask

	// fill every sample the next tick will read, then tick
	task automatic tick_safe();
		int s;
		logic [16:0] rd;
		mix_cmd_t op;
		for (s = 0; s < NVOICE; s++) begin
			if (!vc_active[s])
				continue;
			if (vc_pos[s] < vc_len[s])
				rd = {1'b0, vc_base[s]} + vc_pos[s];
			else if (vc_loop[s])
				rd = {1'b0, vc_base[s]};
			else
				continue;
			if (!pcm_written[rd[15:0]]) begin
				op = rand_fields();
				op.cmd = CMD_WRITE;
				op.addr = rd[15:0];
				op.smp = pick_sample();
				drive_item(op, 1'b0, '0);
			end
		end
		op = rand_fields();
		op.cmd = CMD_TICK;
		drive_item(op, 1'b0, '0);
	endtask

	// result side: random stalls, or one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= (!quiet && $urandom_range(99) < 23);
			end
		end
	end

	// compare each result transfer with the oldest expected mix
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (mix_expected.size() == 0) begin
				$error("unexpected mix result: mix_sample %0d", mix_sample);
				fail_count++;
			end else begin
				mon_want = mix_expected.pop_front();
				if (mix_sample !== $signed(mon_want.mix)) begin
					$error("mix_sample: expected %0d, got %0d", $signed(mon_want.mix),
						mix_sample);
					fail_count++;
				end
				if (clipped !== mon_want.clip) begin
					$error("clipped: expected %0d, got %0d", mon_want.clip, clipped);
					fail_count++;
				end
				if (active_mask !== mon_want.mask) begin
					$error("active_mask: expected %h, got %h", mon_want.mask, active_mask);
					fail_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		mix_cmd_t op;
		int pick;
		int r;
		int i;
		bit hold_done;
		bit drain_done;

		hold_done = 1'b0;
		drain_done = 1'b0;
		fail_count = 0;
		items_sent = 0;
		quiet = 1'b0;
		hold_go = 1'b0;
		for (i = 0; i < NVOICE; i++) begin
			vc_base[i] = '0;
			vc_len[i] = '0;
			vc_pos[i] = '0;
			vc_loop[i] = 1'b0;
			vc_active[i] = 1'b0;
		end
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_WRITE;
		address <= '0;
		sample_in <= '0;
		voice_slot <= '0;
		clip_length <= '0;
		loop_enable <= 1'b0;

		// directed table: typed mixes are checked as written, the rest by the shadow
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_UNUSED, 16'hFFFF, 16'h8000, 3'd7, 17'h1FFFF, 1'b1,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_WRITE,  16'hFFFF, 16'h7FFF, 3'd0, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_WRITE,  16'h0000, 16'h7FFF, 3'd0, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_WRITE,  16'h0001, 16'h8000, 3'd0, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		// background voice runs across the address wrap, slot 7 loops over two samples
		tab_add(dir_row(CMD_START,  16'hFFFF, 16'h0000, 3'd0, 17'h00003, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_START,  16'hFFFF, 16'h0000, 3'd7, 17'h00002, 1'b1,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h7FFF, 1'b1, 8'h81));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h7FFF, 1'b1, 8'h81));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'hFFFF, 1'b0, 8'h81));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h7FFF, 1'b0, 8'h80));
		// negative clipping with two one-shot voices
		tab_add(dir_row(CMD_START,  16'h0001, 16'h0000, 3'd3, 17'h00001, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_START,  16'h0001, 16'h0000, 3'd4, 17'h00001, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h8000, 1'b1, 8'h98));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h7FFF, 1'b0, 8'h80));
		// zero length stays silent, busy slot gets replaced by a clip of the full memory depth
		tab_add(dir_row(CMD_START,  16'h0000, 16'h0000, 3'd5, 17'h00000, 1'b1,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_START,  16'h0001, 16'h0000, 3'd7, 17'h10000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h8000, 1'b0, 8'h80));
		tab_add(dir_row(CMD_WRITE,  16'h0002, 16'h5555, 3'd0, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_WRITE,  16'hAAAA, 16'hAAAA, 3'd0, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_START,  16'h0000, 16'h0000, 3'd7, 17'h00000, 1'b0,
			1'b0, 16'h0000, 1'b0, 8'h00));
		tab_add(dir_row(CMD_TICK,   16'h0000, 16'h0000, 3'd0, 17'h00000, 1'b0,
			1'b1, 16'h0000, 1'b0, 8'h00));

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < dir_tab.size(); i++)
			drive_item(dir_tab[i].op, dir_tab[i].typed, dir_tab[i].want);

		// random commands
		items_sent = 0;
		while (items_sent < RAND_ITEMS) begin
			// long hold-off on the result side while ticks keep coming
			if (!hold_done && items_sent >= 300) begin
				hold_done = 1'b1;
				hold_go = 1'b1;
				repeat (20) tick_safe();
			end
			// sender pause until the mixer has drained
			if (!drain_done && items_sent >= 700) begin
				drain_done = 1'b1;
				in_valid <= 1'b0;
				@(posedge clk);
				while (mix_expected.size() != 0)
					@(posedge clk);
			end
			quiet = (items_sent >= 900 && items_sent < 1100);

			pick = $urandom_range(99);
			op = rand_fields();
			if (pick < 4) begin
				op.cmd = CMD_UNUSED;
				drive_item(op, 1'b0, '0);
			end else if (pick < 34) begin
				op.cmd = CMD_WRITE;
				op.addr = pool_addr();
				op.smp = pick_sample();
				drive_item(op, 1'b0, '0);
			end else if (pick < 50) begin
				op.cmd = CMD_START;
				op.addr = pool_addr();
				r = $urandom_range(99);
				if (r < 5)
					op.len = '0;
				else if (r < 8)
					op.len = 17'h10000;
				else if (r < 10)
					op.len = 17'h1FFFF;
				else if (r >= 15)
					op.len = 17'($urandom_range(1, 12));
				drive_item(op, 1'b0, '0);
			end else begin
				tick_safe();
			end
		end

		// wait out the remaining mixes
		in_valid <= 1'b0;
		@(posedge clk);
		while (mix_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
